// ===== hdl/sid_pkg.sv =====
// Package for the ordered set intersection block.
// Holds the opcode codes, the command kinds and the queue entry type.
// No dependencies.
package sid_pkg;

  // Input opcodes.
  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  // Greatest number of results that one compute run gives.
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Width of the value field and of a result value.
  localparam int VALUE_W = 32;

  // Command kinds that travel from the front to the back.
  typedef enum logic [1:0] {
    CMD_LOAD_FIRST,
    CMD_LOAD_SECOND,
    CMD_COMPUTE
  } cmd_t;

  // Head of the command queue as the back sees it.
  typedef struct packed {
    logic                 valid;
    cmd_t                 kind;
    logic [VALUE_W-1:0]   value;
  } cmd_entry_t;

endpackage

// ===== hdl/sid_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sid_front.sv =====
// Front part of the intersection block: accepts items, classifies them and
// keeps them in a two-entry command queue. Depends on sid_pkg.
module sid_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    opcode,
  input  logic [sid_pkg::VALUE_W-1:0]   value,
  input  logic                          pop,
  output logic                          busy,
  output sid_pkg::cmd_entry_t           head
);
  import sid_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t               kind_q  [QDEPTH];
  logic [VALUE_W-1:0] value_q [QDEPTH];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  cmd_t kind_in;
  logic keep;
  logic push;

  // Classify the incoming opcode; the unused code is dropped here.
  always_comb begin
    kind_in = CMD_LOAD_FIRST;
    keep    = 1'b1;
    unique case (opcode)
      OP_LOAD_FIRST:  kind_in = CMD_LOAD_FIRST;
      OP_LOAD_SECOND: kind_in = CMD_LOAD_SECOND;
      OP_COMPUTE:     kind_in = CMD_COMPUTE;
      default:        keep    = 1'b0;
    endcase
  end

  assign busy = (count == 2'(QDEPTH));
  assign push = start && !busy && keep;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr]  <= kind_in;
      value_q[wr_ptr] <= value;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Head of the queue toward the back part.
  always_comb begin
    head.valid = (count != 2'd0);
    head.kind  = kind_q[rd_ptr];
    head.value = value_q[rd_ptr];
  end

endmodule

// ===== hdl/sid_back.sv =====
// Back part of the intersection block: stores loads in the two list RAMs and
// walks them for a compute command. Depends on sid_pkg and sid_ram.
module sid_back #(
  parameter int FIRST_DEPTH  = 32,
  parameter int SECOND_DEPTH = 32,
  parameter int ELEM_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sid_pkg::cmd_entry_t           head,
  output logic                          pop,
  output logic                          strobe,
  output logic [sid_pkg::VALUE_W-1:0]   common_value,
  output logic                          last,
  output logic                          none_found,
  output logic                          overflow
);
  import sid_pkg::*;

  localparam int FA  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int SA  = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int FCW = $clog2(FIRST_DEPTH + 1);
  localparam int SCW = $clog2(SECOND_DEPTH + 1);
  localparam int JW  = (FCW > SCW) ? FCW : SCW;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CAND_RD  = 9'b000000010,
    S_CAND_LD  = 9'b000000100,
    S_SEEN_RD  = 9'b000001000,
    S_SEEN_CMP = 9'b000010000,
    S_SEC_RD   = 9'b000100000,
    S_SEC_CMP  = 9'b001000000,
    S_NEXT     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t                state;
  logic [FCW-1:0]        first_count;
  logic [SCW-1:0]        second_count;
  logic                  dropped;
  logic [FCW-1:0]        idx;
  logic [JW-1:0]         scan;
  logic [RES_CNT_W-1:0]  found;
  logic [ELEM_WIDTH-1:0] cand;
  logic [ELEM_WIDTH-1:0] pend;

  logic [ELEM_WIDTH+VALUE_W-1:0] load_wide;
  logic [ELEM_WIDTH-1:0]         load_elem;
  logic [ELEM_WIDTH+VALUE_W-1:0] pend_wide;
  logic                          we_first;
  logic                          we_second;
  logic [FA-1:0]                 raddr_first;
  logic [ELEM_WIDTH-1:0]         rdata_first;
  logic [ELEM_WIDTH-1:0]         rdata_second;

  // Elements keep the low ELEM_WIDTH bits of the zero-extended value.
  assign load_wide = {ELEM_WIDTH'(0), head.value};
  assign load_elem = load_wide[ELEM_WIDTH-1:0];
  assign pend_wide = {VALUE_W'(0), pend};

  // Loads are taken one per cycle while no compute run is going.
  assign pop       = (state == S_IDLE) && head.valid;
  assign we_first  = pop && (head.kind == CMD_LOAD_FIRST) &&
                     (first_count < FCW'(FIRST_DEPTH));
  assign we_second = pop && (head.kind == CMD_LOAD_SECOND) &&
                     (second_count < SCW'(SECOND_DEPTH));

  // The first list is read at the candidate index or at the scan index.
  assign raddr_first = (state == S_CAND_RD) ? idx[FA-1:0] : scan[FA-1:0];

  sid_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (FIRST_DEPTH)
  ) u_first_ram (
    .clk   (clk),
    .we    (we_first),
    .waddr (first_count[FA-1:0]),
    .wdata (load_elem),
    .raddr (raddr_first),
    .rdata (rdata_first)
  );

  sid_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (SECOND_DEPTH)
  ) u_second_ram (
    .clk   (clk),
    .we    (we_second),
    .waddr (second_count[SA-1:0]),
    .wdata (load_elem),
    .raddr (scan[SA-1:0]),
    .rdata (rdata_second)
  );

  // Candidate and pending result registers.
  always_ff @(posedge clk) begin
    if (state == S_CAND_LD) begin
      cand <= rdata_first;
    end
    if ((state == S_SEC_CMP) && (rdata_second == cand)) begin
      pend <= cand;
    end
  end

  // Result payload; a found value goes out once the next one is found.
  always_ff @(posedge clk) begin
    if ((state == S_SEC_CMP) && (rdata_second == cand) && (found != '0)) begin
      common_value <= pend_wide[VALUE_W-1:0];
      last         <= 1'b0;
      none_found   <= 1'b0;
      overflow     <= dropped;
    end else if (state == S_DONE) begin
      common_value <= (found == '0) ? '0 : pend_wide[VALUE_W-1:0];
      last         <= 1'b1;
      none_found   <= (found == '0);
      overflow     <= dropped;
    end
  end

  // Sequencer: loads, then the walk over both lists for a compute run.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      idx          <= '0;
      scan         <= '0;
      found        <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            case (head.kind)
              CMD_LOAD_FIRST: begin
                if (we_first) begin
                  first_count <= first_count + FCW'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              CMD_LOAD_SECOND: begin
                if (we_second) begin
                  second_count <= second_count + SCW'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              default: begin
                idx   <= '0;
                found <= '0;
                state <= (first_count == '0) ? S_DONE : S_CAND_RD;
              end
            endcase
          end
        end
        S_CAND_RD: begin
          state <= S_CAND_LD;
        end
        S_CAND_LD: begin
          scan <= '0;
          if (idx != '0) begin
            state <= S_SEEN_RD;
          end else begin
            state <= (second_count == '0) ? S_NEXT : S_SEC_RD;
          end
        end
        S_SEEN_RD: begin
          state <= S_SEEN_CMP;
        end
        S_SEEN_CMP: begin
          // An earlier equal element means this value was handled already.
          if (rdata_first == cand) begin
            state <= S_NEXT;
          end else if (scan + JW'(1) == JW'(idx)) begin
            scan  <= '0;
            state <= (second_count == '0) ? S_NEXT : S_SEC_RD;
          end else begin
            scan  <= scan + JW'(1);
            state <= S_SEEN_RD;
          end
        end
        S_SEC_RD: begin
          state <= S_SEC_CMP;
        end
        S_SEC_CMP: begin
          if (rdata_second == cand) begin
            strobe <= (found != '0);
            found  <= found + RES_CNT_W'(1);
            state  <= (found + RES_CNT_W'(1) == RES_CNT_W'(MAX_RESULTS)) ?
                      S_DONE : S_NEXT;
          end else if (scan + JW'(1) == JW'(second_count)) begin
            state <= S_NEXT;
          end else begin
            scan  <= scan + JW'(1);
            state <= S_SEC_RD;
          end
        end
        S_NEXT: begin
          if (idx + FCW'(1) == first_count) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + FCW'(1);
            state <= S_CAND_RD;
          end
        end
        S_DONE: begin
          strobe       <= 1'b1;
          first_count  <= '0;
          second_count <= '0;
          dropped      <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/set_intersection_dedup.sv =====
// Ordered set intersection without repeats. Load items (opcode 0 or 1) are
// taken one per cycle while no compute run is going and are placed into the
// first or second list RAM; a load into a full list is dropped and raises the
// overflow flag of the next compute run. A compute item (opcode 2) emits, in
// order of first appearance in the first list, each distinct value that also
// occurs in the second list, one result per strobe, the final one marked by
// last; an empty intersection gives one result with none_found set and a zero
// value. Both lists are then empty. Opcode 3 is ignored. Items pass through a
// two-entry command queue, and busy is high while that queue is full. A compute
// run holds the queue while it works: it reads each element of the first list
// and checks it against the earlier first-list elements and then against the
// second-list elements one at a time, since each list RAM has one read port
// with a registered output. Results carry no backpressure: the receiver must
// take every strobe. Depends on sid_pkg, sid_front and sid_back.
module set_intersection_dedup #(
  parameter int FIRST_DEPTH  = 32,
  parameter int SECOND_DEPTH = 32,
  parameter int ELEM_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic signed [sid_pkg::VALUE_W-1:0] value,
  output logic                          strobe,
  output logic signed [sid_pkg::VALUE_W-1:0] common_value,
  output logic                          last,
  output logic                          none_found,
  output logic                          overflow
);
  import sid_pkg::*;

  cmd_entry_t         head;
  logic               pop;
  logic [VALUE_W-1:0] result_value;

  // Front part: accept and classify, then queue.
  sid_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .value  (value),
    .pop    (pop),
    .busy   (busy),
    .head   (head)
  );

  // Back part: list storage and the compute walk.
  sid_back #(
    .FIRST_DEPTH  (FIRST_DEPTH),
    .SECOND_DEPTH (SECOND_DEPTH),
    .ELEM_WIDTH   (ELEM_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .common_value (result_value),
    .last         (last),
    .none_found   (none_found),
    .overflow     (overflow)
  );

  assign common_value = result_value;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the ordered set intersection block.
// Drives load and compute commands, predicts every result and checks each strobe.
// Depends on sid_pkg and set_intersection_dedup.
`timescale 1ns / 100ps

module tb_top;
  import sid_pkg::*;

  localparam int         LIST_DEPTH  = 32;
  localparam int         STIM_TARGET = 230;
  localparam int         CYCLE_LIMIT = 500000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // One pending command, or a marker that holds the sender until all results are in.
  typedef struct {
    bit         hold;
    logic [1:0] op;
    logic [31:0] val;
  } cmd_item_t;

  // One expected result of a compute run.
  typedef struct {
    logic [31:0] val;
    logic        last;
    logic        none_found;
    logic        overflow;
  } common_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = OP_LOAD_FIRST;
  logic signed [VALUE_W-1:0] value = '0;
  logic        busy;
  logic        strobe;
  logic signed [VALUE_W-1:0] common_value;
  logic        last;
  logic        none_found;
  logic        overflow;

  cmd_item_t      cmd_queue[$];
  common_result_t common_expected[$];
  cmd_item_t      next_cmd;

  // Shadow copy of the two lists and the drop flag.
  logic [31:0] first_mem[LIST_DEPTH];
  logic [31:0] second_mem[LIST_DEPTH];
  int          first_cnt = 0;
  int          second_cnt = 0;
  bit          dropped = 1'b0;

  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int stim_items = 0;
  int cycle_cnt = 0;

  set_intersection_dedup dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .value        (value),
    .strobe       (strobe),
    .common_value (common_value),
    .last         (last),
    .none_found   (none_found),
    .overflow     (overflow)
  );

  always #5 clk = ~clk;

  // Update the shadow lists for one accepted command and queue the results it causes.
  task automatic track_intersection(input logic [1:0] op, input logic [31:0] val);
    common_result_t r;
    int n;
    bit dup;
    bit hit;
    case (op)
      OP_LOAD_FIRST: begin
        if (first_cnt < LIST_DEPTH) begin
          first_mem[first_cnt] = val;
          first_cnt++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_LOAD_SECOND: begin
        if (second_cnt < LIST_DEPTH) begin
          second_mem[second_cnt] = val;
          second_cnt++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_COMPUTE: begin
        n = 0;
        for (int i = 0; i < first_cnt && n < MAX_RESULTS; i++) begin
          dup = 1'b0;
          hit = 1'b0;
          for (int j = 0; j < i; j++) if (first_mem[j] == first_mem[i]) dup = 1'b1;
          for (int j = 0; j < second_cnt; j++) if (second_mem[j] == first_mem[i]) hit = 1'b1;
          if (!dup && hit) begin
            r.val = first_mem[i];
            r.last = 1'b0;
            r.none_found = 1'b0;
            r.overflow = dropped;
            common_expected.insert(common_expected.size(), r);
            n++;
          end
        end
        if (n == 0) begin
          r.val = '0;
          r.last = 1'b1;
          r.none_found = 1'b1;
          r.overflow = dropped;
          common_expected.insert(common_expected.size(), r);
        end else begin
          r = common_expected.pop_back();
          r.last = 1'b1;
          common_expected.insert(common_expected.size(), r);
        end
        first_cnt = 0;
        second_cnt = 0;
        dropped = 1'b0;
      end
      default: begin
        // The unused opcode leaves everything as it is.
      end
    endcase
  endtask

  // Sender idle rate in percent, switched every 40 transfers.
  function automatic int idle_pct(input int n);
    case ((n / 40) % 4)
      1:       return 79;
      3:       return 13;
      default: return 0;
    endcase
  endfunction

  task automatic push_cmd(input logic [1:0] op, input logic [31:0] val);
    cmd_item_t c;
    c.hold = 1'b0;
    c.op = op;
    c.val = val;
    cmd_queue.insert(cmd_queue.size(), c);
    if (op != OP_UNUSED) stim_items++;
  endtask

  task automatic push_pause();
    cmd_item_t c;
    c.hold = 1'b1;
    c.op = OP_UNUSED;
    c.val = '0;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // Random load sequence from a small pool so that matches and repeats are common.
  task automatic push_random_set(input int nf, input int ns);
    logic [31:0] pool[8];
    int psize;
    int lf;
    int ls;
    logic [31:0] v;
    psize = $urandom_range(1, 6);
    for (int k = 0; k < 8; k++) pool[k] = $urandom;
    lf = nf;
    ls = ns;
    while (lf > 0 || ls > 0) begin
      v = ($urandom_range(99) < 80) ? pool[$urandom_range(psize - 1)] : $urandom;
      if ($urandom_range(9) == 0) push_cmd(OP_UNUSED, $urandom);
      if (ls == 0 || (lf > 0 && $urandom_range(1) == 0)) begin
        push_cmd(OP_LOAD_FIRST, v);
        lf--;
      end else begin
        push_cmd(OP_LOAD_SECOND, v);
        ls--;
      end
    end
    push_cmd(OP_COMPUTE, $urandom);
  endtask

  // Largest run: a full first list, all of it in a full second list, and one dropped load.
  task automatic push_full_sweep();
    logic [31:0] vals[LIST_DEPTH];
    for (int k = 0; k < LIST_DEPTH; k++) vals[k] = $urandom;
    for (int k = 0; k < LIST_DEPTH; k++) push_cmd(OP_LOAD_FIRST, vals[k]);
    for (int k = LIST_DEPTH - 1; k >= 0; k--) push_cmd(OP_LOAD_SECOND, vals[k]);
    push_cmd(OP_LOAD_SECOND, $urandom);
    push_cmd(OP_COMPUTE, $urandom);
  endtask

  // Driver: a transfer takes place at an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Hold the current command until it is taken.
    end else begin
      if (start) begin
        track_intersection(opcode, value);
        accepted_cnt++;
      end
      if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_queue[0].hold) begin
        if (common_expected.size() == 0) void'(cmd_queue.pop_front());
        start <= 1'b0;
      end else if ($urandom_range(99) < idle_pct(accepted_cnt)) begin
        start <= 1'b0;
      end else begin
        next_cmd = cmd_queue.pop_front();
        start <= 1'b1;
        opcode <= next_cmd.op;
        value <= next_cmd.val;
      end
    end
  end

  // Monitor: every strobe is compared with the oldest expected result.
  always @(posedge clk) begin
    common_result_t e;
    if (!rst && strobe) begin
      if (common_expected.size() == 0) begin
        $display("%0t: unexpected result value=%h last=%b none_found=%b overflow=%b",
                 $time, common_value, last, none_found, overflow);
        mismatch_cnt++;
      end else begin
        e = common_expected.pop_front();
        if (common_value !== e.val) begin
          $display("%0t: common_value expected %h actual %h", $time, e.val, common_value);
          mismatch_cnt++;
        end
        if (last !== e.last) begin
          $display("%0t: last expected %b actual %b", $time, e.last, last);
          mismatch_cnt++;
        end
        if (none_found !== e.none_found) begin
          $display("%0t: none_found expected %b actual %b", $time, e.none_found, none_found);
          mismatch_cnt++;
        end
        if (overflow !== e.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, e.overflow, overflow);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, common_expected.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int seq_idx;
    // Compute on empty lists.
    push_cmd(OP_COMPUTE, 32'h0);
    // Extremes, repeats in both lists, and the unused opcode.
    push_cmd(OP_LOAD_FIRST, 32'h8000_0000);
    push_cmd(OP_LOAD_FIRST, 32'h7FFF_FFFF);
    push_cmd(OP_LOAD_FIRST, 32'h0000_0000);
    push_cmd(OP_LOAD_FIRST, 32'hFFFF_FFFF);
    push_cmd(OP_LOAD_FIRST, 32'h8000_0000);
    push_cmd(OP_LOAD_FIRST, 32'h7FFF_FFFF);
    push_cmd(OP_LOAD_SECOND, 32'hFFFF_FFFF);
    push_cmd(OP_LOAD_SECOND, 32'h7FFF_FFFF);
    push_cmd(OP_LOAD_SECOND, 32'h8000_0000);
    push_cmd(OP_LOAD_SECOND, 32'h0000_0005);
    push_cmd(OP_LOAD_SECOND, 32'hFFFF_FFFF);
    push_cmd(OP_UNUSED, 32'hAAAA_5555);
    push_cmd(OP_COMPUTE, 32'hFFFF_FFFF);
    // Disjoint lists give an empty intersection.
    push_cmd(OP_LOAD_FIRST, 32'h1);
    push_cmd(OP_LOAD_SECOND, 32'h2);
    push_cmd(OP_COMPUTE, 32'h0);
    // Second list loaded first, then a single match.
    push_cmd(OP_LOAD_SECOND, 32'h7);
    push_cmd(OP_LOAD_FIRST, 32'h7);
    push_cmd(OP_COMPUTE, 32'h0);
    // Only the second list holds anything.
    push_cmd(OP_LOAD_SECOND, 32'h3);
    push_cmd(OP_COMPUTE, 32'h0);
    push_pause();

    // Random sequences; the first two cover the full lists and a first-list overflow.
    seq_idx = 0;
    while (stim_items < STIM_TARGET) begin
      if (seq_idx == 0) push_full_sweep();
      else if (seq_idx == 1) push_random_set($urandom_range(33, 35), $urandom_range(1, 3));
      else if ($urandom_range(11) == 0) push_random_set(LIST_DEPTH + 1, $urandom_range(0, 4));
      else push_random_set($urandom_range(0, 10), $urandom_range(0, 10));
      if (seq_idx % 6 == 3) push_pause();
      seq_idx++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every result to arrive.
    while (cmd_queue.size() != 0 || start) @(negedge clk);
    while (common_expected.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
